[hdl/vsd_pkg.sv]
package vsd_pkg;

	// Field widths fixed by the interface.
	localparam int POS_W   = 32;
	localparam int SPEED_W = 16;
	localparam int STEP_W  = 16;
	localparam int LIMIT_W = 15;
	localparam int KEEP_W  = 16;
	localparam int SQ_W    = 2 * STEP_W;

	// Default width of the tick counters.
	localparam int COUNT_BITS_DEF = 16;

	// Register reset values.
	localparam logic [STEP_W-1:0]  RST_POS_STEP_STRICT   = 16'd10;
	localparam logic [STEP_W-1:0]  RST_POS_STEP_NORMAL   = 16'd30;
	localparam logic [LIMIT_W-1:0] RST_SPEED_STRICT      = 15'd20;
	localparam logic [LIMIT_W-1:0] RST_SPEED_NORMAL      = 15'd50;
	localparam logic [KEEP_W-1:0]  RST_POS_STRICT_KEEP   = 16'd5;
	localparam logic [KEEP_W-1:0]  RST_POS_NORMAL_KEEP   = 16'd10;
	localparam logic [KEEP_W-1:0]  RST_SPEED_STRICT_KEEP = 16'd5;
	localparam logic [KEEP_W-1:0]  RST_SPEED_NORMAL_KEEP = 16'd10;

	// Register indexes; register i sits at byte address 4*i.
	typedef enum logic [2:0] {
		REG_POS_STEP_STRICT   = 3'd0,
		REG_POS_STEP_NORMAL   = 3'd1,
		REG_SPEED_STRICT      = 3'd2,
		REG_SPEED_NORMAL      = 3'd3,
		REG_POS_STRICT_KEEP   = 3'd4,
		REG_POS_NORMAL_KEEP   = 3'd5,
		REG_SPEED_STRICT_KEEP = 3'd6,
		REG_SPEED_NORMAL_KEEP = 3'd7
	} reg_idx_t;

	// Input beat.
	typedef struct packed {
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [SPEED_W-1:0] speed;
	} sample_t;

	// Result beat.
	typedef struct packed {
		logic standstill;
		logic still_by_position;
		logic still_by_speed;
	} result_t;

	// Configuration handed from the register file to the datapath.
	typedef struct packed {
		logic [SQ_W-1:0]    step_strict_sq;
		logic [SQ_W-1:0]    step_normal_sq;
		logic [LIMIT_W-1:0] speed_strict;
		logic [LIMIT_W-1:0] speed_normal;
		logic [KEEP_W-1:0]  pos_strict_keep;
		logic [KEEP_W-1:0]  pos_normal_keep;
		logic [KEEP_W-1:0]  speed_strict_keep;
		logic [KEEP_W-1:0]  speed_normal_keep;
	} cfg_t;

endpackage

[hdl/vehicle_standstill_detector.sv]
// Standstill detector: takes one position/speed sample per beat and returns one result beat
// per sample. A sample may be accepted in every clock cycle while the result beat is not stalled;
// the edge that accepts it loads the input register, and the result register then takes its
// result beat once the result slot frees up. The throughput of one sample per cycle is set
// by the update loop of the last position and the four tick counters, which closes between
// the input register and the result register. Counters count samples, saturate at full
// scale and clear when their condition fails. Thresholds are to be written over the APB
// port only while no sample is in flight; the block itself does not enforce this.
module vehicle_standstill_detector #(
	parameter int COUNT_BITS = vsd_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  vsd_pkg::sample_t  sample,
	output logic              result_valid,
	input  logic              result_ready,
	output vsd_pkg::result_t  result
);
	import vsd_pkg::*;

	cfg_t cfg;

	// Configuration registers.
	vsd_regs u_regs (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cfg(cfg)
	);

	// Detection datapath.
	vsd_core #(.COUNT_BITS(COUNT_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

endmodule

[hdl/vsd_regs.sv]
module vsd_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output vsd_pkg::cfg_t       cfg
);
	import vsd_pkg::*;

	logic [STEP_W-1:0]  pos_step_strict_q;
	logic [STEP_W-1:0]  pos_step_normal_q;
	logic [LIMIT_W-1:0] speed_strict_q;
	logic [LIMIT_W-1:0] speed_normal_q;
	logic [KEEP_W-1:0]  pos_strict_keep_q;
	logic [KEEP_W-1:0]  pos_normal_keep_q;
	logic [KEEP_W-1:0]  speed_strict_keep_q;
	logic [KEEP_W-1:0]  speed_normal_keep_q;
	logic [SQ_W-1:0]    step_strict_sq_q;
	logic [SQ_W-1:0]    step_normal_sq_q;
	logic               wr_en;
	reg_idx_t           idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_step_strict_q   <= RST_POS_STEP_STRICT;
			pos_step_normal_q   <= RST_POS_STEP_NORMAL;
			speed_strict_q      <= RST_SPEED_STRICT;
			speed_normal_q      <= RST_SPEED_NORMAL;
			pos_strict_keep_q   <= RST_POS_STRICT_KEEP;
			pos_normal_keep_q   <= RST_POS_NORMAL_KEEP;
			speed_strict_keep_q <= RST_SPEED_STRICT_KEEP;
			speed_normal_keep_q <= RST_SPEED_NORMAL_KEEP;
		end else if (wr_en) begin
			case (idx)
				REG_POS_STEP_STRICT:   pos_step_strict_q   <= pwdata[STEP_W-1:0];
				REG_POS_STEP_NORMAL:   pos_step_normal_q   <= pwdata[STEP_W-1:0];
				REG_SPEED_STRICT:      speed_strict_q      <= pwdata[LIMIT_W-1:0];
				REG_SPEED_NORMAL:      speed_normal_q      <= pwdata[LIMIT_W-1:0];
				REG_POS_STRICT_KEEP:   pos_strict_keep_q   <= pwdata[KEEP_W-1:0];
				REG_POS_NORMAL_KEEP:   pos_normal_keep_q   <= pwdata[KEEP_W-1:0];
				REG_SPEED_STRICT_KEEP: speed_strict_keep_q <= pwdata[KEEP_W-1:0];
				REG_SPEED_NORMAL_KEEP: speed_normal_keep_q <= pwdata[KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Squared step thresholds, kept in registers so the datapath only compares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_strict_sq_q <= SQ_W'(RST_POS_STEP_STRICT) * SQ_W'(RST_POS_STEP_STRICT);
			step_normal_sq_q <= SQ_W'(RST_POS_STEP_NORMAL) * SQ_W'(RST_POS_STEP_NORMAL);
		end else begin
			step_strict_sq_q <= SQ_W'(pos_step_strict_q) * SQ_W'(pos_step_strict_q);
			step_normal_sq_q <= SQ_W'(pos_step_normal_q) * SQ_W'(pos_step_normal_q);
		end
	end

	// Read back.
	always_comb begin
		case (idx)
			REG_POS_STEP_STRICT:   prdata = 32'(pos_step_strict_q);
			REG_POS_STEP_NORMAL:   prdata = 32'(pos_step_normal_q);
			REG_SPEED_STRICT:      prdata = 32'(speed_strict_q);
			REG_SPEED_NORMAL:      prdata = 32'(speed_normal_q);
			REG_POS_STRICT_KEEP:   prdata = 32'(pos_strict_keep_q);
			REG_POS_NORMAL_KEEP:   prdata = 32'(pos_normal_keep_q);
			REG_SPEED_STRICT_KEEP: prdata = 32'(speed_strict_keep_q);
			REG_SPEED_NORMAL_KEEP: prdata = 32'(speed_normal_keep_q);
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		cfg.step_strict_sq    = step_strict_sq_q;
		cfg.step_normal_sq    = step_normal_sq_q;
		cfg.speed_strict      = speed_strict_q;
		cfg.speed_normal      = speed_normal_q;
		cfg.pos_strict_keep   = pos_strict_keep_q;
		cfg.pos_normal_keep   = pos_normal_keep_q;
		cfg.speed_strict_keep = speed_strict_keep_q;
		cfg.speed_normal_keep = speed_normal_keep_q;
	end

endmodule

[hdl/vsd_tick_counter.sv]
module vsd_tick_counter #(
	parameter int COUNT_BITS = vsd_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  hold,
	output logic [COUNT_BITS-1:0] count_next
);
	import vsd_pkg::*;

	logic [COUNT_BITS-1:0] count_q;

	// Count up while the condition holds, stop at full scale, clear otherwise.
	always_comb begin
		if (!hold) begin
			count_next = '0;
		end else if (&count_q) begin
			count_next = count_q;
		end else begin
			count_next = count_q + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_next;
		end
	end

endmodule

[hdl/vsd_core.sv]
module vsd_core #(
	parameter int COUNT_BITS = vsd_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vsd_pkg::cfg_t     cfg,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  vsd_pkg::sample_t  sample,
	output logic              result_valid,
	input  logic              result_ready,
	output vsd_pkg::result_t  result
);
	import vsd_pkg::*;

	localparam int CMP_W  = (COUNT_BITS > KEEP_W) ? COUNT_BITS : KEEP_W;
	localparam int DIFF_W = POS_W + 1;
	localparam int AV_W   = SPEED_W + 1;

	sample_t               sample_s1;
	logic                  valid_s1;
	result_t               result_s2;
	logic                  valid_s2;
	logic                  advance;
	logic                  step_en;
	logic signed [POS_W-1:0] last_x_q;
	logic signed [POS_W-1:0] last_y_q;
	logic [DIFF_W-1:0]     dx;
	logic [DIFF_W-1:0]     dy;
	logic [DIFF_W-1:0]     ax;
	logic [DIFF_W-1:0]     ay;
	logic [AV_W-1:0]       sp_ext;
	logic [AV_W-1:0]       av;
	logic                  small_step;
	logic [SQ_W:0]         d2;
	logic                  hold_pos_strict;
	logic                  hold_pos_normal;
	logic                  hold_speed_strict;
	logic                  hold_speed_normal;
	logic [COUNT_BITS-1:0] pos_strict_next;
	logic [COUNT_BITS-1:0] pos_normal_next;
	logic [COUNT_BITS-1:0] speed_strict_next;
	logic [COUNT_BITS-1:0] speed_normal_next;
	logic                  by_pos;
	logic                  by_speed;

	// Handshake: the input register moves on whenever the result slot frees up.
	assign advance      = !valid_s2 || result_ready;
	assign sample_ready = !valid_s1 || advance;
	assign step_en      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
	end

	// Step from the last position, magnitude per axis.
	always_comb begin
		dx = {sample_s1.pos_x[POS_W-1], sample_s1.pos_x} - {last_x_q[POS_W-1], last_x_q};
		dy = {sample_s1.pos_y[POS_W-1], sample_s1.pos_y} - {last_y_q[POS_W-1], last_y_q};
		ax = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
		ay = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
		small_step = (ax[DIFF_W-1:STEP_W] == '0) && (ay[DIFF_W-1:STEP_W] == '0);
		d2 = (SQ_W+1)'(ax[STEP_W-1:0] * ax[STEP_W-1:0])
		   + (SQ_W+1)'(ay[STEP_W-1:0] * ay[STEP_W-1:0]);
	end

	// Speed magnitude; the most negative value maps to 32768 exactly.
	always_comb begin
		sp_ext = {sample_s1.speed[SPEED_W-1], sample_s1.speed};
		av     = sp_ext[AV_W-1] ? (~sp_ext + AV_W'(1)) : sp_ext;
	end

	// Conditions that keep each counter running.
	assign hold_pos_strict   = small_step && (d2 < (SQ_W+1)'(cfg.step_strict_sq));
	assign hold_pos_normal   = small_step && (d2 < (SQ_W+1)'(cfg.step_normal_sq));
	assign hold_speed_strict = av < AV_W'(cfg.speed_strict);
	assign hold_speed_normal = av < AV_W'(cfg.speed_normal);

	vsd_tick_counter #(.COUNT_BITS(COUNT_BITS)) u_pos_strict (
		.clk(clk), .arst_n(arst_n), .en(step_en), .hold(hold_pos_strict),
		.count_next(pos_strict_next)
	);
	vsd_tick_counter #(.COUNT_BITS(COUNT_BITS)) u_pos_normal (
		.clk(clk), .arst_n(arst_n), .en(step_en), .hold(hold_pos_normal),
		.count_next(pos_normal_next)
	);
	vsd_tick_counter #(.COUNT_BITS(COUNT_BITS)) u_speed_strict (
		.clk(clk), .arst_n(arst_n), .en(step_en), .hold(hold_speed_strict),
		.count_next(speed_strict_next)
	);
	vsd_tick_counter #(.COUNT_BITS(COUNT_BITS)) u_speed_normal (
		.clk(clk), .arst_n(arst_n), .en(step_en), .hold(hold_speed_normal),
		.count_next(speed_normal_next)
	);

	// Flags from the updated counts.
	assign by_pos   = (CMP_W'(pos_strict_next) > CMP_W'(cfg.pos_strict_keep))
	               || (CMP_W'(pos_normal_next) > CMP_W'(cfg.pos_normal_keep));
	assign by_speed = (CMP_W'(speed_strict_next) > CMP_W'(cfg.speed_strict_keep))
	               || (CMP_W'(speed_normal_next) > CMP_W'(cfg.speed_normal_keep));

	// The last position follows every processed sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (step_en) begin
			last_x_q <= sample_s1.pos_x;
			last_y_q <= sample_s1.pos_y;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_s2.standstill        <= by_pos && by_speed;
			result_s2.still_by_position <= by_pos;
			result_s2.still_by_speed    <= by_speed;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

[hdl/vsd_checker.sv]
module vsd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pready,
	input logic              sample_valid,
	input logic              sample_ready,
	input logic              result_valid,
	input logic              result_ready,
	input vsd_pkg::result_t  result
);
	import vsd_pkg::*;

	// A stalled result beat holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// Standstill is exactly both criteria together.
	a_standstill_and: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.standstill == (result.still_by_position && result.still_by_speed))
		else $error("standstill flag disagrees with its criteria");

	// A result appearing from empty comes from a sample accepted into the input register before it.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
		else $error("result beat without a matching sample");

	// With the result slot free, the block always takes a sample.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("sample refused while result slot is empty");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind vehicle_standstill_detector vsd_checker u_vsd_checker (
	.clk(clk), .arst_n(arst_n), .pready(pready),
	.sample_valid(sample_valid), .sample_ready(sample_ready),
	.result_valid(result_valid), .result_ready(result_ready), .result(result)
);
